// ===== rtl/core/mpq_pkg.sv =====
// Shared types and codes for the min priority queue core.
// No dependencies; imported by mpq_ctrl and min_priority_queue_core.
package mpq_pkg;

   localparam int CAPACITY_DEF = 64;
   localparam int KEY_W        = 32;
   localparam int OPCODE_W     = 2;
   localparam int COUNT_W      = 7;
   localparam int STATUS_W     = 2;

   localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_REMOVE = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_PEEK   = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic [OPCODE_W-1:0]     opcode;
      logic signed [KEY_W-1:0] key;
   } req_item_type;

   typedef struct packed {
      logic signed [KEY_W-1:0] min_key;
      logic [COUNT_W-1:0]      entry_count;
      logic [STATUS_W-1:0]     status;
   } rsp_item_type;

endpackage

// ===== rtl/core/mpq_ram.sv =====
// Heap storage: one write port, two read ports, registered read data.
// Stand-alone; used by mpq_ctrl through the top level.
module mpq_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 32,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr_a,
   input  logic [AW-1:0]    rd_addr_b,
   output logic [WIDTH-1:0] rd_data_a,
   output logic [WIDTH-1:0] rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a_ff <= mem[rd_addr_a];
      rd_data_b_ff <= mem[rd_addr_b];
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

// ===== rtl/core/mpq_ctrl.sv =====
// Binary heap sequencer: sift-up on insert, sift-down on remove, one level a cycle.
// Depends on mpq_pkg; drives the ports of mpq_ram.
module mpq_ctrl #(
   parameter int CAPACITY = mpq_pkg::CAPACITY_DEF,
   localparam int AW      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
   localparam int CW      = $clog2(CAPACITY + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  mpq_pkg::req_item_type req_item,
   output logic                  res_valid,
   input  logic                  res_take,
   output mpq_pkg::rsp_item_type res_item,
   output logic                  wr_en,
   output logic [AW-1:0]         wr_addr,
   output logic [mpq_pkg::KEY_W-1:0] wr_data,
   output logic [AW-1:0]         rd_addr_a,
   output logic [AW-1:0]         rd_addr_b,
   input  logic [mpq_pkg::KEY_W-1:0] rd_data_a,
   input  logic [mpq_pkg::KEY_W-1:0] rd_data_b
);
   import mpq_pkg::*;

   localparam int XW = CW + 1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_LAST,
      S_DOWN,
      S_UP,
      S_PLACE,
      S_DONE
   } state_type;

   state_type               state_ff, state_in;
   logic [CW-1:0]           cnt_ff, cnt_in;
   logic [AW-1:0]           idx_ff, idx_in;
   logic signed [KEY_W-1:0] hold_ff, hold_in;
   logic signed [KEY_W-1:0] min_ff, min_in;
   logic [STATUS_W-1:0]     status_ff, status_in;

   logic [XW-1:0]           cnt_ext;
   logic [XW-1:0]           cur_l, cur_r;
   logic [AW-1:0]           probe_idx;
   logic [XW-1:0]           probe_l, probe_r;
   logic                    go_right;
   logic signed [KEY_W-1:0] child_key;
   logic [AW-1:0]           child_idx;
   logic [AW-1:0]           parent_idx;
   logic [AW-1:0]           parent_of_parent;
   logic [AW-1:0]           ins_parent;

   assign cnt_ext          = XW'(cnt_ff);
   assign cur_l            = XW'({idx_ff, 1'b1});
   assign cur_r            = cur_l + XW'(1);
   assign go_right         = (cur_r < cnt_ext) && ($signed(rd_data_b) < $signed(rd_data_a));
   assign child_key        = go_right ? $signed(rd_data_b) : $signed(rd_data_a);
   assign child_idx        = go_right ? cur_r[AW-1:0] : cur_l[AW-1:0];
   assign parent_idx       = AW'((idx_ff - AW'(1)) >> 1);
   assign parent_of_parent = AW'((parent_idx - AW'(1)) >> 1);
   assign ins_parent       = AW'((cnt_ff - CW'(1)) >> 1);
   assign probe_idx        = (state_ff == S_DOWN) ? child_idx : '0;
   assign probe_l          = XW'({probe_idx, 1'b1});
   assign probe_r          = probe_l + XW'(1);

   assign req_ready = (state_ff == S_IDLE);
   assign res_valid = (state_ff == S_DONE);

   always_comb begin
      res_item.min_key     = (cnt_ff == '0) ? '0 : min_ff;
      res_item.entry_count = COUNT_W'(cnt_ff);
      res_item.status      = status_ff;
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      idx_in    = idx_ff;
      hold_in   = hold_ff;
      status_in = status_ff;
      wr_en     = 1'b0;
      wr_addr   = idx_ff;
      wr_data   = hold_ff;
      rd_addr_a = '0;
      rd_addr_b = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in  = S_DONE;
               status_in = ST_OK;
               case (req_item.opcode)
                  OP_INSERT: begin
                     if (cnt_ff == CW'(CAPACITY)) begin
                        status_in = ST_FULL;
                     end else begin
                        cnt_in  = cnt_ff + CW'(1);
                        hold_in = req_item.key;
                        idx_in  = AW'(cnt_ff);
                        if (cnt_ff == '0) begin
                           wr_en   = 1'b1;
                           wr_addr = '0;
                           wr_data = req_item.key;
                        end else begin
                           rd_addr_a = ins_parent;
                           state_in  = S_UP;
                        end
                     end
                  end
                  OP_REMOVE: begin
                     if (cnt_ff == '0) begin
                        status_in = ST_EMPTY;
                     end else begin
                        cnt_in = cnt_ff - CW'(1);
                        if (cnt_ff != CW'(1)) begin
                           // fetch the last entry; it refills the root
                           rd_addr_a = AW'(cnt_ff - CW'(1));
                           state_in  = S_LAST;
                        end
                     end
                  end
                  default: begin
                     if (cnt_ff == '0) begin
                        status_in = ST_EMPTY;
                     end
                  end
               endcase
            end
         end
         S_LAST: begin
            hold_in = rd_data_a;
            idx_in  = '0;
            if (probe_l < cnt_ext) begin
               rd_addr_a = probe_l[AW-1:0];
               rd_addr_b = probe_r[AW-1:0];
               state_in  = S_DOWN;
            end else begin
               wr_en    = 1'b1;
               wr_addr  = '0;
               wr_data  = rd_data_a;
               state_in = S_DONE;
            end
         end
         S_DOWN: begin
            if (child_key < hold_ff) begin
               // promote the smaller child and descend
               wr_en   = 1'b1;
               wr_data = child_key;
               idx_in  = child_idx;
               if (probe_l < cnt_ext) begin
                  rd_addr_a = probe_l[AW-1:0];
                  rd_addr_b = probe_r[AW-1:0];
               end else begin
                  state_in = S_PLACE;
               end
            end else begin
               wr_en    = 1'b1;
               state_in = S_DONE;
            end
         end
         S_UP: begin
            if ($signed(rd_data_a) > hold_ff) begin
               // move the parent down and climb
               wr_en   = 1'b1;
               wr_data = rd_data_a;
               idx_in  = parent_idx;
               if (parent_idx == '0) begin
                  state_in = S_PLACE;
               end else begin
                  rd_addr_a = parent_of_parent;
               end
            end else begin
               wr_en    = 1'b1;
               state_in = S_DONE;
            end
         end
         S_PLACE: begin
            wr_en    = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (res_take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // the root is cached so the minimum needs no read
      min_in = min_ff;
      if (wr_en && (wr_addr == '0)) begin
         min_in = wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         cnt_ff    <= '0;
         status_ff <= ST_OK;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         status_ff <= status_in;
      end
      idx_ff  <= idx_in;
      hold_ff <= hold_in;
      min_ff  <= min_in;
   end

endmodule

// ===== rtl/core/min_priority_queue_core.sv =====
// Min priority queue on a binary heap held in a two-read, one-write RAM.
// Insert sifts up and remove sifts down, one heap level per cycle; peek and rejected
// items go straight to the result.
// One item in flight; the next is taken once the result sits in the output register.
// Synchronous reset empties the queue at once; heap RAM contents are not cleared.
// Depends on mpq_pkg, mpq_ram and mpq_ctrl.
module min_priority_queue_core #(
   parameter int CAPACITY = mpq_pkg::CAPACITY_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  mpq_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output mpq_pkg::rsp_item_type rsp_item
);
   import mpq_pkg::*;

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   logic             res_valid;
   logic             res_take;
   rsp_item_type     res_item;
   logic             wr_en;
   logic [AW-1:0]    wr_addr;
   logic [KEY_W-1:0] wr_data;
   logic [AW-1:0]    rd_addr_a;
   logic [AW-1:0]    rd_addr_b;
   logic [KEY_W-1:0] rd_data_a;
   logic [KEY_W-1:0] rd_data_b;

   logic             rsp_valid_ff, rsp_valid_in;
   rsp_item_type     rsp_item_ff, rsp_item_in;

   mpq_ram #(
      .DEPTH (CAPACITY),
      .WIDTH (KEY_W)
   ) u_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   mpq_ctrl #(
      .CAPACITY (CAPACITY)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .res_valid (res_valid),
      .res_take  (res_take),
      .res_item  (res_item),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   // output slot is free when empty or being drained this cycle
   assign res_take = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;
      if (res_valid && res_take) begin
         rsp_valid_in = 1'b1;
         rsp_item_in  = res_item;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

// ===== tb/min_priority_queue_core_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for min_priority_queue_core: directed table, then random
// fill/drain/mixed traffic, checked against a shadow multiset of held keys.
// Depends on mpq_pkg and the min_priority_queue_core RTL.
module min_priority_queue_core_tb;
   import mpq_pkg::*;

   localparam int CAP          = CAPACITY_DEF;
   localparam int RANDOM_ITEMS = 650;
   localparam int QUIET_ITEMS  = 80;
   localparam int TAIL_CYCLES  = 16;
   localparam int CYCLE_LIMIT  = 250000;
   localparam int PRINT_LIMIT  = 40;

   localparam logic [OPCODE_W-1:0] OP_UNDEF = 2'd3;
   localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7fffffff;
   localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh80000000;

   typedef enum {PH_FILL, PH_DRAIN, PH_MIX} traffic_phase_type;

   typedef struct {
      logic [OPCODE_W-1:0]     opcode;
      logic signed [KEY_W-1:0] key;
      bit                      typed;
      rsp_item_type            want;
   } plan_row_type;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   req_item_type req_item;
   logic         rsp_valid;
   logic         rsp_ready;
   rsp_item_type rsp_item;

   // typed expectation travelling alongside the item on the request channel
   bit           row_typed;
   rsp_item_type row_expect;

   logic signed [KEY_W-1:0] shadow_keys [CAP];
   int           shadow_count;
   rsp_item_type pending_results [$];

   bit quiet_tail;
   bit sender_gaps;
   int mismatches;
   int cycle_count;
   int results_seen;
   int n_insert, n_remove, n_peek, n_full, n_empty, peak_count;

   min_priority_queue_core #(.CAPACITY(CAP)) uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic int lowest_slot();
      int best;
      best = 0;
      for (int i = 1; i < shadow_count; i++) begin
         if (shadow_keys[i] < shadow_keys[best]) best = i;
      end
      return best;
   endfunction

   // Apply one item to the shadow queue and return the result it must give.
   function automatic rsp_item_type apply_op(req_item_type it);
      rsp_item_type r;
      int slot;
      r = '0;
      r.status = ST_OK;
      case (it.opcode)
         OP_INSERT: begin
            if (shadow_count >= CAP) begin
               r.status = ST_FULL;
            end else begin
               shadow_keys[shadow_count] = it.key;
               shadow_count++;
            end
         end
         OP_REMOVE: begin
            if (shadow_count == 0) begin
               r.status = ST_EMPTY;
            end else begin
               slot = lowest_slot();
               shadow_keys[slot] = shadow_keys[shadow_count - 1];
               shadow_count--;
            end
         end
         default: begin
            // peek, and the unused opcode behaves the same
            if (shadow_count == 0) r.status = ST_EMPTY;
         end
      endcase
      if (shadow_count > 0) r.min_key = shadow_keys[lowest_slot()];
      r.entry_count = COUNT_W'(shadow_count);
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      if (mismatches < PRINT_LIMIT) $display("MISMATCH at %0t ns: %s", $time, msg);
      mismatches++;
   endtask

   // Predict on every accepted item, check every accepted result.
   always @(posedge clock) begin
      rsp_item_type model_rsp;
      rsp_item_type want_rsp;
      cycle_count++;
      if (!reset) begin
         if (req_valid && req_ready) begin
            model_rsp = apply_op(req_item);
            case (req_item.opcode)
               OP_INSERT: n_insert++;
               OP_REMOVE: n_remove++;
               default:   n_peek++;
            endcase
            if (model_rsp.status == ST_FULL) n_full++;
            if (model_rsp.status == ST_EMPTY) n_empty++;
            if (shadow_count > peak_count) peak_count = shadow_count;
            pending_results.push_back(row_typed ? row_expect : model_rsp);
         end
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
               report_mismatch($sformatf("result with nothing outstanding: min %0d count %0d",
                                         rsp_item.min_key, rsp_item.entry_count));
            end else begin
               want_rsp = pending_results.pop_front();
               if (rsp_item.min_key !== want_rsp.min_key)
                  report_mismatch($sformatf("result %0d min_key %0d, want %0d", results_seen,
                                            rsp_item.min_key, want_rsp.min_key));
               if (rsp_item.entry_count !== want_rsp.entry_count)
                  report_mismatch($sformatf("result %0d entry_count %0d, want %0d",
                                            results_seen, rsp_item.entry_count,
                                            want_rsp.entry_count));
               if (rsp_item.status !== want_rsp.status)
                  report_mismatch($sformatf("result %0d status %0d, want %0d", results_seen,
                                            rsp_item.status, want_rsp.status));
            end
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("TIMEOUT after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("min_priority_queue_core_tb failed");
      $finish;
   end

   // Result side: stall in bursts, with calm stretches, and never near the end.
   initial begin
      int stretch_left;
      bit stalls_on;
      stretch_left = 0;
      stalls_on = 1'b0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stretch_left == 0) begin
            stretch_left = $urandom_range(20, 150);
            stalls_on = ($urandom_range(0, 2) != 0);
         end
         stretch_left--;
         if (!reset && !quiet_tail && stalls_on && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   // Hold the item until taken, then maybe leave a gap.
   task automatic drive_item(input logic [OPCODE_W-1:0] opcode,
                             input logic signed [KEY_W-1:0] key,
                             input bit typed, input rsp_item_type want);
      req_item_type it;
      it.opcode = opcode;
      it.key    = key;
      req_item   <= it;
      req_valid  <= 1'b1;
      row_typed  <= typed;
      row_expect <= want;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (!quiet_tail && sender_gaps && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
   endtask

   // Step one edge first so the last accepted item is already outstanding.
   task automatic drain_outstanding();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   initial begin
      plan_row_type plan [$];
      traffic_phase_type phase;
      int planned_count, full_tries, empty_tries, mix_left, pick;
      logic [OPCODE_W-1:0] op;
      logic signed [KEY_W-1:0] key;

      reset <= 1'b1;
      req_valid <= 1'b0;
      req_item <= '0;
      row_typed <= 1'b0;
      row_expect <= '0;
      quiet_tail = 1'b0;
      sender_gaps = 1'b1;

      // empty queue, unused opcode, extremes, duplicates, last-key removal
      plan.push_back('{OP_PEEK,   32'sd0,          1'b1, {32'sd0, 7'd0, ST_EMPTY}});
      plan.push_back('{OP_REMOVE, KEY_MAX,         1'b1, {32'sd0, 7'd0, ST_EMPTY}});
      plan.push_back('{OP_UNDEF,  KEY_MIN,         1'b1, {32'sd0, 7'd0, ST_EMPTY}});
      plan.push_back('{OP_INSERT, KEY_MAX,         1'b1, {KEY_MAX, 7'd1, ST_OK}});
      plan.push_back('{OP_INSERT, KEY_MIN,         1'b1, {KEY_MIN, 7'd2, ST_OK}});
      plan.push_back('{OP_INSERT, 32'sd0,          1'b1, {KEY_MIN, 7'd3, ST_OK}});
      plan.push_back('{OP_INSERT, -32'sd1,         1'b0, '0});
      plan.push_back('{OP_INSERT, KEY_MIN,         1'b0, '0});
      plan.push_back('{OP_REMOVE, -32'sd1,         1'b0, '0});
      plan.push_back('{OP_UNDEF,  32'sd5,          1'b0, '0});
      plan.push_back('{OP_REMOVE, 32'sd0,          1'b0, '0});
      plan.push_back('{OP_REMOVE, 32'sd0,          1'b0, '0});
      plan.push_back('{OP_REMOVE, 32'sd0,          1'b0, '0});
      plan.push_back('{OP_REMOVE, 32'sd0,          1'b1, {32'sd0, 7'd0, ST_OK}});
      plan.push_back('{OP_REMOVE, 32'sd0,          1'b1, {32'sd0, 7'd0, ST_EMPTY}});
      plan.push_back('{OP_INSERT, 32'sh55555555,   1'b0, '0});
      plan.push_back('{OP_INSERT, 32'shaaaaaaaa,   1'b0, '0});
      plan.push_back('{OP_INSERT, 32'sd1,          1'b0, '0});
      plan.push_back('{OP_PEEK,   32'sh12345678,   1'b0, '0});
      plan.push_back('{OP_INSERT, 32'shaaaaaaaa,   1'b0, '0});
      plan.push_back('{OP_REMOVE, 32'shffffffff,   1'b0, '0});
      plan.push_back('{OP_REMOVE, 32'sd0,          1'b0, '0});
      plan.push_back('{OP_REMOVE, 32'sd0,          1'b0, '0});
      plan.push_back('{OP_REMOVE, 32'sd0,          1'b1, {32'sd0, 7'd0, ST_OK}});

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[i]) drive_item(plan[i].opcode, plan[i].key, plan[i].typed, plan[i].want);
      drain_outstanding();

      // Random part: fill to capacity, drain to empty, then mixed traffic, round again.
      phase = PH_FILL;
      planned_count = 0;
      full_tries = 0;
      empty_tries = 0;
      mix_left = 0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         quiet_tail = (n >= RANDOM_ITEMS - QUIET_ITEMS);
         if (phase == PH_FILL && full_tries >= 3) begin
            phase = PH_DRAIN;
            empty_tries = 0;
            sender_gaps = $urandom_range(0, 1);
            drain_outstanding();
         end else if (phase == PH_DRAIN && empty_tries >= 2) begin
            phase = PH_MIX;
            mix_left = $urandom_range(30, 80);
            sender_gaps = $urandom_range(0, 1);
         end else if (phase == PH_MIX && mix_left == 0) begin
            phase = PH_FILL;
            full_tries = 0;
            sender_gaps = 1'b1;
         end
         if (phase == PH_MIX) mix_left--;

         pick = $urandom_range(0, 99);
         case (phase)
            PH_FILL:  op = (pick < 80) ? OP_INSERT : (pick < 90) ? OP_REMOVE :
                           (pick < 98) ? OP_PEEK : OP_UNDEF;
            PH_DRAIN: op = (pick < 80) ? OP_REMOVE : (pick < 90) ? OP_INSERT :
                           (pick < 98) ? OP_PEEK : OP_UNDEF;
            default:  op = (pick < 45) ? OP_INSERT : (pick < 85) ? OP_REMOVE :
                           (pick < 97) ? OP_PEEK : OP_UNDEF;
         endcase

         // wide keys, a narrow band for duplicates, and the extremes
         pick = $urandom_range(0, 9);
         if (pick < 5) begin
            key = $urandom();
         end else if (pick < 8) begin
            key = $signed($urandom_range(0, 8)) - 32'sd4;
         end else begin
            case ($urandom_range(0, 4))
               0: key = KEY_MAX;
               1: key = KEY_MIN;
               2: key = 32'sd0;
               3: key = -32'sd1;
               default: key = 32'sd1;
            endcase
         end

         if (op == OP_INSERT) begin
            if (planned_count >= CAP) full_tries++;
            else planned_count++;
         end else if (op == OP_REMOVE) begin
            if (planned_count == 0) empty_tries++;
            else planned_count--;
         end else if (planned_count == 0) begin
            empty_tries++;
         end

         drive_item(op, key, 1'b0, '0);
      end

      drain_outstanding();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Covered %0d inserts (%0d refused at capacity), %0d removes, %0d peeks;",
               n_insert, n_full, n_remove, n_peek);
      $display("%0d results checked, %0d on an empty queue, peak occupancy %0d of %0d",
               results_seen, n_empty, peak_count, CAP);
      if (mismatches == 0) begin
         $display("min_priority_queue_core_tb passed");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("min_priority_queue_core_tb failed");
      end
      $finish;
   end

endmodule
